// File: hdl/json_string_unescape_utf8_macros.svh
// ----------------------------------------------------------------------------
// JSON string unescaper assertion macros
// Shared concurrent assertion forms used by the unescaper modules.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define JSU_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSU_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// JSON string unescaper package
// Beat types, the decoded run descriptor and the character helper functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
    logic       escape_error;
  } out_t;

  // One decoded input beat: up to three bytes plus the flags of its last result.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            last;
    logic            err;
  } run_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_LOWER_B   = 8'h62;
  localparam logic [7:0] CH_LOWER_F   = 8'h66;
  localparam logic [7:0] CH_LOWER_N   = 8'h6e;
  localparam logic [7:0] CH_LOWER_R   = 8'h72;
  localparam logic [7:0] CH_LOWER_T   = 8'h74;
  localparam logic [7:0] CH_LOWER_U   = 8'h75;

  localparam logic [15:0] UTF8_MAX1 = 16'h007f;
  localparam logic [15:0] UTF8_MAX2 = 16'h07ff;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'he0;
  localparam logic [7:0]  UTF8_CONT  = 8'h80;

  // Hex digit of either case; anything else is flagged and counts as zero.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b0, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b0, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b0, 4'(c - 8'h37)};
    end else begin
      r = 5'h10;
    end
    return r;
  endfunction

endpackage

// File: hdl/json_string_unescape_utf8.sv
// ----------------------------------------------------------------------------
// JSON string body unescaper with UTF-8 output
// Decodes backslash and \uXXXX escapes of a JSON string body to bytes.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+---------------------------------
//   item     | in        | push / full        | data_byte, string_end
//   result   | out       | empty / pop        | out_byte, byte_valid, run_last,
//            |           |                    | string_done, escape_error
//
// An input beat is taken every cycle while the run queue has room. Each beat
// yields zero to three result beats; a beat that yields k results holds the
// output side until all k are popped. A three-byte UTF-8 sequence yields
// three results, but its escape took six input beats, so with pop held
// high the queue never fills and full rises only when the receiver holds
// off. An accepted beat is queued, then loaded as the current run, before
// its first result can be popped. The synchronous reset clears the escape
// phase, the run queue and the output stage; nothing else needs clearing.
//
// Structure: the front end classifies each body byte against the escape
// phase and turns it into a run descriptor (bytes plus end and error flags).
// The run queue lets the front keep accepting while the back end unrolls a
// longer run into single-byte result beats.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8
  import jsu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  in_t  item,
  output logic empty,
  input  logic pop,
  output out_t result
);

  // Front end to queue.
  logic wr_en;
  run_t wr_data;
  logic q_full;

  // Queue to back end.
  logic q_rd;
  run_t q_data;
  logic q_not_empty;

  // The block is full exactly when the run queue is, since every accepted
  // beat may need a queue slot.
  assign full = q_full;

  jsu_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item    (item),
    .q_full  (q_full),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  jsu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_data   (wr_data),
    .full      (q_full),
    .rd_en     (q_rd),
    .rd_data   (q_data),
    .not_empty (q_not_empty)
  );

  // The back end holds the current run and presents one result beat at a
  // time; its last beat and the next run's load happen in the same cycle.
  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_data      (q_data),
    .q_rd        (q_rd),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule

// File: hdl/jsu_front.sv
// ----------------------------------------------------------------------------
// JSON string unescaper front end
// Accepts body bytes, tracks the escape phase and decodes each beat to a run.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  in_t  item,
  input  logic q_full,
  output logic wr_en,
  output run_t wr_data
);

  localparam logic [2:0] PH_PLAIN  = 3'd0;
  localparam logic [2:0] PH_ESCAPE = 3'd1;
  localparam logic [2:0] PH_HEX1   = 3'd2;
  localparam logic [2:0] PH_HEX4   = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [15:0] acc, acc_next;
  logic        accept;
  logic [4:0]  hv;
  logic [15:0] acc_shift;
  logic [7:0]  c;
  run_t        run;

  assign accept = push && !q_full;
  assign c      = item.data_byte;
  assign hv     = hex_value(c);
  assign acc_shift = {acc[11:0], hv[3:0]};

  always_comb begin
    phase_next  = phase;
    acc_next    = acc;
    run.bytes   = '0;
    run.nbytes  = 2'd0;
    run.last    = item.string_end;
    run.err     = 1'b0;
    if (phase == PH_ESCAPE) begin
      phase_next = PH_PLAIN;
      run.nbytes = 2'd1;
      unique case (c)
        CH_LOWER_B:   run.bytes[0] = 8'h08;
        CH_LOWER_F:   run.bytes[0] = 8'h0c;
        CH_LOWER_N:   run.bytes[0] = 8'h0a;
        CH_LOWER_R:   run.bytes[0] = 8'h0d;
        CH_LOWER_T:   run.bytes[0] = 8'h09;
        CH_BACKSLASH: run.bytes[0] = CH_BACKSLASH;
        CH_QUOTE:     run.bytes[0] = CH_QUOTE;
        CH_SLASH:     run.bytes[0] = CH_SLASH;
        CH_LOWER_U: begin
          phase_next = PH_HEX1;
          acc_next   = '0;
          run.nbytes = 2'd0;
        end
        default: begin
          run.nbytes = 2'd0;
          run.err    = 1'b1;
        end
      endcase
    end else if (phase >= PH_HEX1 && phase <= PH_HEX4) begin
      run.err  = hv[4];
      acc_next = acc_shift;
      if (phase == PH_HEX4) begin
        phase_next = PH_PLAIN;
        acc_next   = '0;
        if (acc_shift <= UTF8_MAX1) begin
          run.nbytes   = 2'd1;
          run.bytes[0] = acc_shift[7:0];
        end else if (acc_shift <= UTF8_MAX2) begin
          run.nbytes   = 2'd2;
          run.bytes[0] = UTF8_LEAD2 | {3'b000, acc_shift[10:6]};
          run.bytes[1] = UTF8_CONT | {2'b00, acc_shift[5:0]};
        end else begin
          run.nbytes   = 2'd3;
          run.bytes[0] = UTF8_LEAD3 | {4'b0000, acc_shift[15:12]};
          run.bytes[1] = UTF8_CONT | {2'b00, acc_shift[11:6]};
          run.bytes[2] = UTF8_CONT | {2'b00, acc_shift[5:0]};
        end
      end else begin
        phase_next = phase + 3'd1;
      end
    end else begin
      if (c == CH_BACKSLASH) begin
        phase_next = PH_ESCAPE;
      end else begin
        phase_next   = PH_PLAIN;
        run.nbytes   = 2'd1;
        run.bytes[0] = c;
      end
    end
    if (item.string_end) begin
      // An escape left open at the end of the string is an error.
      if (phase_next != PH_PLAIN) begin
        run.err = 1'b1;
      end
      phase_next = PH_PLAIN;
      acc_next   = '0;
    end
  end

  assign wr_en   = accept && (run.nbytes != 2'd0 || run.err || run.last);
  assign wr_data = run;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_PLAIN;
      acc   <= '0;
    end else if (accept) begin
      phase <= phase_next;
      acc   <= acc_next;
    end
  end

endmodule

// File: hdl/jsu_fifo.sv
// ----------------------------------------------------------------------------
// JSON string unescaper run queue
// Small register queue of decoded runs between the front and back ends.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_macros.svh"

module jsu_fifo
  import jsu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  run_t wr_data,
  output logic full,
  input  logic rd_en,
  output run_t rd_data,
  output logic not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  run_t          mem [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [CW-1:0] cnt;
  logic          do_wr, do_rd;

  assign full      = (cnt == CW'(DEPTH));
  assign not_empty = (cnt != '0);
  assign do_wr     = wr_en && !full;
  assign do_rd     = rd_en && not_empty;
  assign rd_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (do_rd) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `JSU_ASSERT_NEXT(a_cnt_up, clk, rst, do_wr && !do_rd, cnt == $past(cnt) + 1'b1, "count did not rise")
  `JSU_ASSERT_NEXT(a_cnt_down, clk, rst, do_rd && !do_wr, cnt == $past(cnt) - 1'b1, "count did not fall")

endmodule

// File: hdl/jsu_back.sv
// ----------------------------------------------------------------------------
// JSON string unescaper back end
// Unrolls each decoded run into result beats, at most one byte per beat.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_macros.svh"

module jsu_back
  import jsu_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_not_empty,
  input  run_t q_data,
  output logic q_rd,
  output logic empty,
  input  logic pop,
  output out_t result
);

  run_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic [1:0] total;
  logic       last_beat;
  logic       take;
  logic       load;

  assign total     = (cur.nbytes == 2'd0) ? 2'd1 : cur.nbytes;
  assign last_beat = (idx == total - 2'd1);
  assign take      = pop && cur_valid;
  assign load      = q_not_empty && (!cur_valid || (take && last_beat));
  assign q_rd      = load;
  assign empty     = !cur_valid;

  always_comb begin
    result.byte_valid   = (idx < cur.nbytes);
    result.out_byte     = result.byte_valid ? cur.bytes[idx] : 8'h00;
    result.run_last     = last_beat;
    result.string_done  = last_beat && cur.last;
    result.escape_error = last_beat && cur.err;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur <= q_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= 1'b1;
      idx       <= '0;
    end else if (take) begin
      if (last_beat) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  `JSU_ASSERT_IMPL(a_idx_range, clk, rst, cur_valid, idx < total, "beat index past run length")
  `JSU_ASSERT_NEXT(a_hold_beat, clk, rst, cur_valid && !pop, $stable(result) && !empty, "waiting beat changed")

endmodule
